### hdl/rgb2hsv_pkg.sv
// Shared types, constants and the divider step for the RGB to HSV pixel converter.
// No dependencies; the top level rgb_to_hsv_pixel imports this package.
`default_nettype none

package rgb2hsv_pkg;

  // Hue scale: one sixth of a turn and a full turn in 1/64 degree units.
  localparam logic [14:0] HUE_SIXTH = 15'd3840;
  localparam logic [14:0] HUE_FULL  = 15'd23040;

  // Sector offsets for the green and blue maximum cases.
  localparam logic [14:0] HUE_OFS_GREEN = 15'd7680;
  localparam logic [14:0] HUE_OFS_BLUE  = 15'd15360;

  // One quotient bit is resolved per pipeline stage.
  localparam int DIV_STEPS = 16;

  // Which channel holds the maximum, in test order.
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One restoring divider lane: partial remainder and the numerator bits
  // still to be shifted in, which fill up with quotient bits from the right.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] work;
  } div_lane_t;

  // Everything that travels down the divider stages with one word.
  typedef struct packed {
    div_lane_t   sat;
    div_lane_t   hue;
    logic [7:0]  mx;
    logic [7:0]  delta;
    sector_t     sector;
    logic        neg;
    logic        grey;
    logic        black;
  } div_stage_t;

  // One restoring step: bring down the next numerator bit, subtract the
  // divisor if it fits and record the quotient bit.
  function automatic div_lane_t div_step(div_lane_t lane, logic [7:0] divisor);
    logic [8:0] trial;
    logic       fits;
    div_lane_t  res;
    trial = {lane.rem, lane.work[15]};
    fits  = (trial >= {1'b0, divisor});
    res.rem  = fits ? 8'(trial - {1'b0, divisor}) : trial[7:0];
    res.work = {lane.work[14:0], fits};
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/rgb2hsv_pix_if.sv
// Input channel: one RGB pixel word with valid/ready handshake.
// No dependencies.
`default_nettype none

interface rgb2hsv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

### hdl/rgb2hsv_res_if.sv
// Output channel: one HSV result word with valid/ready handshake.
// No dependencies.
`default_nettype none

interface rgb2hsv_res_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue;
  logic [15:0] saturation;
  logic [7:0]  brightness;
  logic        hue_undefined;

  modport source (output valid, output hue, output saturation, output brightness,
                  output hue_undefined, input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  input hue_undefined, output ready);
endinterface

`default_nettype wire

### hdl/rgb_to_hsv_pixel.sv
// RGB to HSV pixel converter, top level.
// Depends on rgb2hsv_pkg, rgb2hsv_pix_if and rgb2hsv_res_if.
//
// Usage:
//   pix carries one 8-bit RGB pixel per word; res carries hue (1/64 degree),
//   saturation (0..65535), brightness (largest channel) and hue_undefined,
//   which is set only for a black pixel. A word moves when valid and ready
//   are both high at a rising clock edge.
// Pipeline and throughput:
//   A pixel accepted at one edge passes on its way to res through
//   19 registers: max/min (loaded at the accepting edge),
//   numerators, 16 restoring divider stages that each resolve one quotient
//   bit for saturation and hue side by side, and the output register that
//   applies the sector offset. One pixel per clock while res is taken.
// Reset:
//   rst is synchronous and active high; it clears every stage valid bit and
//   the output valid, so the pipeline restarts empty.
// Stalls:
//   When res holds a word that is not taken, the whole pipeline freezes and
//   pix.ready drops in the same cycle; no word is lost or repeated.
`default_nettype none

module rgb_to_hsv_pixel (
  input  logic                 clk,
  input  logic                 rst,
  rgb2hsv_pix_if.sink          pix,
  rgb2hsv_res_if.source        res
);
  import rgb2hsv_pkg::*;

  // Pipeline moves when the output register is empty or being emptied.
  logic advance;
  assign advance   = !res.valid || res.ready;
  assign pix.ready = advance;

  // Max, min and the signed channel difference of the sector.
  logic [7:0] mx_in;
  logic [7:0] mn_in;
  sector_t    sector_in;
  logic [8:0] diff_in;
  logic [7:0] mag_in;

  always_comb begin
    mx_in = (pix.red > pix.green) ? pix.red : pix.green;
    mx_in = (mx_in > pix.blue) ? mx_in : pix.blue;
    mn_in = (pix.red < pix.green) ? pix.red : pix.green;
    mn_in = (mn_in < pix.blue) ? mn_in : pix.blue;
    priority if (pix.red == mx_in) begin
      sector_in = SECT_RED;
      diff_in   = {1'b0, pix.green} - {1'b0, pix.blue};
    end else if (pix.green == mx_in) begin
      sector_in = SECT_GREEN;
      diff_in   = {1'b0, pix.blue} - {1'b0, pix.red};
    end else begin
      sector_in = SECT_BLUE;
      diff_in   = {1'b0, pix.red} - {1'b0, pix.green};
    end
    mag_in = diff_in[8] ? 8'(-diff_in) : diff_in[7:0];
  end

  // Stage 1 registers.
  logic       s1_valid;
  logic [7:0] s1_mx;
  logic [7:0] s1_delta;
  sector_t    s1_sector;
  logic       s1_neg;
  logic [7:0] s1_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mx     <= mx_in;
      s1_delta  <= mx_in - mn_in;
      s1_sector <= sector_in;
      s1_neg    <= diff_in[8];
      s1_mag    <= mag_in;
    end
  end

  // Rounded numerators: delta*65535 + max/2 and mag*3840 + delta/2.
  // Constant multiplies are written as shift and subtract.
  logic [23:0] sat_num;
  logic [23:0] hue_num;
  div_stage_t  div_first;

  always_comb begin
    sat_num = {s1_delta, 16'h0000} - {16'h0000, s1_delta} + {17'h00000, s1_mx[7:1]};
    hue_num = {4'h0, s1_mag, 12'h000} - {8'h00, s1_mag, 8'h00}
              + {17'h00000, s1_delta[7:1]};
    div_first.sat.rem  = sat_num[23:16];
    div_first.sat.work = sat_num[15:0];
    div_first.hue.rem  = hue_num[23:16];
    div_first.hue.work = hue_num[15:0];
    div_first.mx       = s1_mx;
    div_first.delta    = s1_delta;
    div_first.sector   = s1_sector;
    div_first.neg      = s1_neg;
    div_first.grey     = (s1_delta == 8'h00);
    div_first.black    = (s1_mx == 8'h00);
  end

  // Divider pipeline: entry 0 holds the numerators, each later entry one
  // more quotient bit. The quotient fits 16 bits because delta <= max.
  div_stage_t           dv       [DIV_STEPS+1];
  logic [DIV_STEPS:0]   dv_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid <= '0;
    end else if (advance) begin
      dv_valid <= {dv_valid[DIV_STEPS-1:0], s1_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dv[0] <= div_first;
    end
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (advance) begin
        dv[i+1].sat    <= div_step(dv[i].sat, dv[i].mx);
        dv[i+1].hue    <= div_step(dv[i].hue, dv[i].delta);
        dv[i+1].mx     <= dv[i].mx;
        dv[i+1].delta  <= dv[i].delta;
        dv[i+1].sector <= dv[i].sector;
        dv[i+1].neg    <= dv[i].neg;
        dv[i+1].grey   <= dv[i].grey;
        dv[i+1].black  <= dv[i].black;
      end
    end
  end

  // Apply sector offset and sign, wrap negative hue by a full turn.
  div_stage_t  dv_last;
  logic [14:0] hue_ofs;
  logic [15:0] hue_q;
  logic [15:0] hue_sum;
  logic [15:0] hue_wrap;
  logic [14:0] hue_out;
  logic [15:0] sat_out;

  always_comb begin
    dv_last = dv[DIV_STEPS];
    unique case (dv_last.sector)
      SECT_RED:   hue_ofs = 15'd0;
      SECT_GREEN: hue_ofs = HUE_OFS_GREEN;
      SECT_BLUE:  hue_ofs = HUE_OFS_BLUE;
      default:    hue_ofs = 15'd0;
    endcase
    hue_q    = dv_last.hue.work;
    hue_sum  = dv_last.neg ? ({1'b0, hue_ofs} - hue_q) : ({1'b0, hue_ofs} + hue_q);
    hue_wrap = hue_sum[15] ? (hue_sum + {1'b0, HUE_FULL}) : hue_sum;
    hue_out  = (dv_last.grey || dv_last.black) ? 15'd0 : hue_wrap[14:0];
    sat_out  = dv_last.black ? 16'h0000 : dv_last.sat.work;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= dv_valid[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.hue           <= hue_out;
      res.saturation    <= sat_out;
      res.brightness    <= dv_last.mx;
      res.hue_undefined <= dv_last.black;
    end
  end

endmodule

`default_nettype wire
